@@ rtl/thv_pkg.sv @@
package thv_pkg;

    localparam int HEADER_BYTES       = 40;
    localparam int MAX_MIP_LEVELS_DEF = 16;

    localparam int CNT_W = 64;
    localparam int SUM_W = 36;
    localparam int DIM_W = 16;
    localparam int MIP_W = 5;
    localparam int VER_W = 32;

    localparam logic [VER_W-1:0] SCHEMA_RST  = 32'd1;
    localparam logic [DIM_W-1:0] MAX_DIM_RST = 16'd16384;

    // "ATLTEX\0\0", byte i at bits [8i+7:8i]
    localparam logic [63:0] MAGIC = 64'h0000_5845_544C_5441;

    // header word positions (byte offset / 4)
    localparam logic [3:0] WORD_VERSION = 4'd2;
    localparam logic [3:0] WORD_WIDTH   = 4'd3;
    localparam logic [3:0] WORD_HEIGHT  = 4'd4;
    localparam logic [3:0] WORD_FORMAT  = 4'd5;
    localparam logic [3:0] WORD_MIPS    = 4'd6;
    localparam logic [3:0] WORD_OFFSET  = 4'd7;
    localparam logic [3:0] WORD_SIZE    = 4'd8;
    localparam logic [3:0] WORD_LAYOUT  = 4'd9;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_TRUNC   = 4'd1,
        ST_MAGIC   = 4'd2,
        ST_VERSION = 4'd3,
        ST_DIM     = 4'd4,
        ST_FORMAT  = 4'd5,
        ST_MIPS    = 4'd6,
        ST_LAYOUT  = 4'd7,
        ST_ALIGN   = 4'd8,
        ST_SIZE    = 4'd9
    } t_status;

    typedef enum logic {
        CFG_SCHEMA  = 1'b0,
        CFG_MAX_DIM = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             bc7;
        logic [MIP_W-1:0] mips;
    } t_chain_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
    } t_chain_rsp;

endpackage

@@ rtl/thv_in_if.sv @@
interface thv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

@@ rtl/thv_out_if.sv @@
interface thv_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        done_res;
    logic [3:0]  status;
    logic [15:0] tex_width;
    logic [15:0] tex_height;
    logic        color_srgb;
    logic        layout_bc7;
    logic [4:0]  mip_levels;

    modport source (
        output valid, output payload_valid, output payload_byte, output done_res,
        output status, output tex_width, output tex_height, output color_srgb,
        output layout_bc7, output mip_levels, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input done_res,
        input status, input tex_width, input tex_height, input color_srgb,
        input layout_bc7, input mip_levels, output ready
    );
endinterface

@@ rtl/thv_chain.sv @@
module thv_chain
    import thv_pkg::*;
#(
    parameter int LVL_W = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain_req i_req,
    output t_chain_rsp o_rsp
);

    logic             r_busy;
    logic             r_prod_v;
    logic [LVL_W-1:0] r_left;
    logic [DIM_W-1:0] r_lw;
    logic [DIM_W-1:0] r_lh;
    logic             r_bc7;
    logic [SUM_W-1:0] r_prod;
    logic [SUM_W-1:0] r_acc;

    logic [DIM_W:0]     w_plus3;
    logic [DIM_W:0]     h_plus3;
    logic [DIM_W-1:0]   op_a;
    logic [DIM_W-1:0]   op_b;
    logic [2*DIM_W-1:0] prod;
    logic [SUM_W-1:0]   scaled;
    logic [DIM_W-1:0]   n_lw;
    logic [DIM_W-1:0]   n_lh;

    always_comb begin
        w_plus3 = {1'b0, r_lw} + (DIM_W+1)'(3);
        h_plus3 = {1'b0, r_lh} + (DIM_W+1)'(3);
        op_a    = r_bc7 ? {1'b0, w_plus3[DIM_W:2]} : r_lw;
        op_b    = r_bc7 ? {1'b0, h_plus3[DIM_W:2]} : r_lh;
        prod    = op_a * op_b;
        // 16 bytes per 4x4 block, 4 bytes per texel
        scaled  = r_bc7 ? {prod, 4'b0} : {2'b0, prod, 2'b0};
        n_lw    = ((r_lw >> 1) == '0) ? DIM_W'(1) : (r_lw >> 1);
        n_lh    = ((r_lh >> 1) == '0) ? DIM_W'(1) : (r_lh >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_prod_v <= 1'b0;
            r_left   <= '0;
        end else if (i_req.start) begin
            r_busy   <= 1'b1;
            r_prod_v <= 1'b0;
            r_left   <= i_req.mips[LVL_W-1:0];
            r_lw     <= i_req.w;
            r_lh     <= i_req.h;
            r_bc7    <= i_req.bc7;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_left != '0) begin
                r_prod   <= scaled;
                r_prod_v <= 1'b1;
                r_left   <= r_left - LVL_W'(1);
                r_lw     <= n_lw;
                r_lh     <= n_lh;
            end else begin
                r_prod_v <= 1'b0;
            end
            if (r_prod_v) begin
                r_acc <= r_acc + r_prod;
            end
            if (r_left == '0 && !r_prod_v) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_busy && (r_left == '0) && !r_prod_v;
    assign o_rsp.sum  = r_acc;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("chain restarted while busy");

    a_prod_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_v |-> r_busy) else $error("product pending outside a run");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !r_busy) else $error("chain still busy after done");

endmodule

@@ rtl/texture_header_validator.sv @@
// A byte's result is registered in the output register as the byte is accepted.
// The final header byte waits for the header check (S_CHECK) and, if it passes,
// the mip-chain walk (S_CHAIN) in the multiply-accumulate unit thv_chain.
// Throughput: one byte per cycle unless the output stalls or a header is checked.
// Reset: synchronous, active low; clears stream state, schema_version = 1,
// max_dimension = 16384.
module texture_header_validator
    import thv_pkg::*;
#(
    parameter int MAX_MIP_LEVELS = MAX_MIP_LEVELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [VER_W-1:0] i_cfg_data,
    thv_in_if.sink           i_in,
    thv_out_if.source        o_res
);

    localparam int LVL_W = $clog2(MAX_MIP_LEVELS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_CHAIN,
        S_RESULT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    t_status          r_err;
    logic             r_hdr_ok;
    logic [SUM_W-1:0] r_total;
    logic             r_fin_pend;

    logic [VER_W-1:0] r_schema;
    logic [DIM_W-1:0] r_max_dim;

    logic             r_magic_bad;
    logic [23:0]      r_asm;
    logic [VER_W-1:0] r_version;
    logic [DIM_W-1:0] r_w;
    logic             r_w_big;
    logic [DIM_W-1:0] r_h;
    logic             r_h_big;
    logic             r_fmt_bad;
    logic             r_srgb;
    logic [MIP_W-1:0] r_mips;
    logic             r_mips_big;
    logic             r_off_bad;
    logic [31:0]      r_size;
    logic             r_lay_bad;
    logic             r_bc7;

    logic             r_out_valid;
    logic             r_out_pv;
    logic [7:0]       r_out_byte;
    logic             r_out_done;
    t_status          r_out_status;
    logic [DIM_W-1:0] r_out_w;
    logic [DIM_W-1:0] r_out_h;
    logic             r_out_srgb;
    logic             r_out_bc7;
    logic [MIP_W-1:0] r_out_mips;

    logic             out_free;
    logic             in_ready;
    logic             in_acc;
    logic [CNT_W-1:0] cnt_inc;
    logic             is_hdr;
    logic             is_hdr_end;
    logic [31:0]      word;
    logic             res_fin;
    logic [CNT_W-1:0] res_cnt;
    logic             res_pv;
    t_status          res_status;
    logic             dim_bad;
    logic [DIM_W-1:0] wh_or;
    logic [MIP_W-1:0] mips_m1;
    logic             mips_bad;
    logic             align_bad;
    t_status          chk_err;
    t_chain_req       chain_req;
    t_chain_rsp       chain_rsp;

    assign out_free   = !r_out_valid || o_res.ready;
    assign in_ready   = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in.valid && in_ready;
    assign cnt_inc    = (&r_cnt) ? r_cnt : r_cnt + CNT_W'(1);
    assign is_hdr     = r_cnt < CNT_W'(HEADER_BYTES);
    assign is_hdr_end = r_cnt == CNT_W'(HEADER_BYTES - 1);
    assign word       = {i_in.in_byte, r_asm};

    always_comb begin
        if (r_state == S_RESULT) begin
            res_fin = r_fin_pend;
            res_cnt = r_cnt;
            res_pv  = 1'b0;
        end else begin
            res_fin = i_in.last;
            res_cnt = cnt_inc;
            res_pv  = !is_hdr && r_hdr_ok;
        end
        if (!res_fin) begin
            res_status = r_err;
        end else if (res_cnt < CNT_W'(HEADER_BYTES)) begin
            res_status = ST_TRUNC;
        end else if (r_err != ST_OK) begin
            res_status = r_err;
        end else if (res_cnt != CNT_W'(r_total)) begin
            res_status = ST_SIZE;
        end else begin
            res_status = ST_OK;
        end
    end

    always_comb begin
        dim_bad   = (r_w == '0) || r_w_big || (r_w > r_max_dim) ||
                    (r_h == '0) || r_h_big || (r_h > r_max_dim);
        wh_or     = r_w | r_h;
        mips_m1   = r_mips - MIP_W'(1);
        // chain length >= mips  <=>  max(w,h) >= 2^(mips-1)
        mips_bad  = (r_mips == '0) || r_mips_big || (r_mips > MIP_W'(MAX_MIP_LEVELS)) ||
                    ((wh_or >> mips_m1[3:0]) == '0);
        align_bad = r_bc7 && ((r_w[1:0] != 2'b00) || (r_h[1:0] != 2'b00));
        if (r_magic_bad) begin
            chk_err = ST_MAGIC;
        end else if (r_version != r_schema) begin
            chk_err = ST_VERSION;
        end else if (dim_bad) begin
            chk_err = ST_DIM;
        end else if (r_fmt_bad) begin
            chk_err = ST_FORMAT;
        end else if (mips_bad) begin
            chk_err = ST_MIPS;
        end else if (r_lay_bad) begin
            chk_err = ST_LAYOUT;
        end else if (align_bad) begin
            chk_err = ST_ALIGN;
        end else if (r_off_bad) begin
            chk_err = ST_SIZE;
        end else begin
            chk_err = ST_OK;
        end
    end

    assign chain_req.start = (r_state == S_CHECK) && (chk_err == ST_OK);
    assign chain_req.w     = r_w;
    assign chain_req.h     = r_h;
    assign chain_req.bc7   = r_bc7;
    assign chain_req.mips  = r_mips;

    thv_chain #(
        .LVL_W (LVL_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (chain_req),
        .o_rsp   (chain_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_schema  <= SCHEMA_RST;
            r_max_dim <= MAX_DIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCHEMA:  r_schema  <= i_cfg_data;
                CFG_MAX_DIM: r_max_dim <= i_cfg_data[DIM_W-1:0];
                default:     r_schema  <= r_schema;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_hdr_ok    <= 1'b0;
            r_total     <= '0;
            r_magic_bad <= 1'b0;
            r_fin_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cnt <= cnt_inc;
                        if (is_hdr) begin
                            if (r_cnt < CNT_W'(8) &&
                                i_in.in_byte != MAGIC[8*r_cnt[2:0] +: 8]) begin
                                r_magic_bad <= 1'b1;
                            end
                            r_asm <= {i_in.in_byte, r_asm[23:8]};
                            if (r_cnt[1:0] == 2'b11) begin
                                case (r_cnt[5:2])
                                    WORD_VERSION: r_version <= word;
                                    WORD_WIDTH: begin
                                        r_w     <= word[DIM_W-1:0];
                                        r_w_big <= |word[31:DIM_W];
                                    end
                                    WORD_HEIGHT: begin
                                        r_h     <= word[DIM_W-1:0];
                                        r_h_big <= |word[31:DIM_W];
                                    end
                                    WORD_FORMAT: begin
                                        r_fmt_bad <= |word[31:1];
                                        r_srgb    <= word[0];
                                    end
                                    WORD_MIPS: begin
                                        r_mips     <= word[MIP_W-1:0];
                                        r_mips_big <= |word[31:MIP_W];
                                    end
                                    WORD_OFFSET: r_off_bad <= word != 32'(HEADER_BYTES);
                                    WORD_SIZE:   r_size    <= word;
                                    WORD_LAYOUT: begin
                                        r_lay_bad <= |word[31:1];
                                        r_bc7     <= word[0];
                                    end
                                    default: r_asm <= {i_in.in_byte, r_asm[23:8]};
                                endcase
                            end
                        end
                        if (is_hdr_end) begin
                            r_fin_pend <= i_in.last;
                            r_state    <= S_CHECK;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_pv     <= res_pv;
                            r_out_byte   <= res_pv ? i_in.in_byte : 8'd0;
                            r_out_done   <= res_fin;
                            r_out_status <= res_status;
                            r_out_w      <= r_hdr_ok ? r_w : '0;
                            r_out_h      <= r_hdr_ok ? r_h : '0;
                            r_out_srgb   <= r_hdr_ok && r_srgb;
                            r_out_bc7    <= r_hdr_ok && r_bc7;
                            r_out_mips   <= r_hdr_ok ? r_mips : '0;
                            if (i_in.last) begin
                                r_cnt       <= '0;
                                r_err       <= ST_OK;
                                r_hdr_ok    <= 1'b0;
                                r_total     <= '0;
                                r_magic_bad <= 1'b0;
                            end
                        end
                    end
                end
                S_CHECK: begin
                    if (chk_err == ST_OK) begin
                        r_state <= S_CHAIN;
                    end else begin
                        r_err   <= chk_err;
                        r_state <= S_RESULT;
                    end
                end
                S_CHAIN: begin
                    if (chain_rsp.done) begin
                        if (SUM_W'(r_size) != chain_rsp.sum) begin
                            r_err <= ST_SIZE;
                        end else begin
                            r_err    <= ST_OK;
                            r_hdr_ok <= 1'b1;
                            r_total  <= chain_rsp.sum + SUM_W'(HEADER_BYTES);
                        end
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_pv     <= 1'b0;
                        r_out_byte   <= 8'd0;
                        r_out_done   <= res_fin;
                        r_out_status <= res_status;
                        r_out_w      <= r_hdr_ok ? r_w : '0;
                        r_out_h      <= r_hdr_ok ? r_h : '0;
                        r_out_srgb   <= r_hdr_ok && r_srgb;
                        r_out_bc7    <= r_hdr_ok && r_bc7;
                        r_out_mips   <= r_hdr_ok ? r_mips : '0;
                        r_state      <= S_IDLE;
                        if (r_fin_pend) begin
                            r_cnt       <= '0;
                            r_err       <= ST_OK;
                            r_hdr_ok    <= 1'b0;
                            r_total     <= '0;
                            r_magic_bad <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.payload_valid = r_out_pv;
    assign o_res.payload_byte  = r_out_byte;
    assign o_res.done_res      = r_out_done;
    assign o_res.status        = r_out_status;
    assign o_res.tex_width     = r_out_w;
    assign o_res.tex_height    = r_out_h;
    assign o_res.color_srgb    = r_out_srgb;
    assign o_res.layout_bc7    = r_out_bc7;
    assign o_res.mip_levels    = r_out_mips;

    a_chain_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_rsp.done |-> r_state == S_CHAIN) else $error("chain done outside chain walk");

    a_ok_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_ok |-> r_err == ST_OK) else $error("header ok with latched error");

    a_hdr_end_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_hdr_end) |=> r_state == S_CHECK) else $error("header end not checked");

endmodule

@@ test/tb_texture_header_validator.sv @@
module tb_texture_header_validator;
    import thv_pkg::*;

    localparam int N_DIRECTED       = 22;
    localparam int RANDOM_PER_PHASE = 275;
    localparam int STALL_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 24;
    localparam int MAX_REPORTS      = 40;
    localparam logic [63:0] BAD_MAGIC = MAGIC ^ 64'h0100_0000_0000_0000;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        done_res;
        t_status     status;
        logic [15:0] tex_width;
        logic [15:0] tex_height;
        logic        color_srgb;
        logic        layout_bc7;
        logic [4:0]  mip_levels;
    } t_byte_result;

    typedef struct {
        logic [63:0] magic;
        logic [31:0] ver, w, h, fmt, mips, off, size, lay;
    } t_header;

    // size_adj: added to the chain size in the header
    // payload bytes: (pay_exact ? chain size : 0) + pay_adj
    // cut: header byte that carries last, -1 for none
    typedef struct {
        logic [63:0] magic;
        logic [31:0] ver, w, h, fmt, mips, lay, off;
        int          size_adj;
        bit          pay_exact;
        int          pay_adj;
        int          cut;
        bit          pinned;
        t_status     pin_st;
    } t_case;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [VER_W-1:0] cfg_data;

    thv_in_if  in_ch();
    thv_out_if res_ch();

    texture_header_validator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    logic [31:0] cfg_schema;
    logic [15:0] cfg_max_dim;

    logic [7:0]  hdr_mem [HEADER_BYTES];
    logic [63:0] seen_bytes;
    t_status     hdr_err;
    logic [63:0] chain_expect;
    bit          hdr_valid;

    t_byte_result stream_results_q [$];
    logic [7:0]   art_q [$];

    int      fail_count;
    int      sent_bytes;
    int      quiet;
    bit      steady;
    bit      pin_hold;
    t_status pin_code;

    t_case directed_cases [N_DIRECTED] = '{
        '{MAGIC,     32'd1, 4,     4,     0,      3, 0, 40, 0, 1,  0, -1, 1, ST_OK},
        '{MAGIC,     32'd1, 8,     4,     1,      4, 1, 40, 0, 1,  0, -1, 0, ST_OK},
        '{MAGIC,     32'd1, 1,     1,     1,      1, 0, 40, 0, 1,  3, -1, 1, ST_SIZE},
        '{MAGIC,     32'd1, 2,     3,     0,      2, 0, 40, 0, 1, -1, -1, 1, ST_SIZE},
        '{MAGIC,     32'd1, 1,     1,     0,      1, 0, 40, 0, 0,  0, -1, 1, ST_SIZE},
        '{MAGIC,     32'd1, 4,     4,     0,      1, 0, 40, 0, 0,  0,  0, 1, ST_TRUNC},
        '{BAD_MAGIC, 32'd1, 4,     4,     0,      1, 0, 40, 0, 0,  0, 38, 1, ST_TRUNC},
        '{BAD_MAGIC, 32'd1, 4,     4,     0,      1, 0, 40, 0, 0,  3, -1, 1, ST_MAGIC},
        '{MAGIC,     32'd2, 4,     4,     0,      1, 0, 40, 0, 0,  2, -1, 1, ST_VERSION},
        '{MAGIC,     32'd1, 0,     4,     0,      1, 0, 40, 0, 0,  2, -1, 1, ST_DIM},
        '{MAGIC,     32'd1, 4,     16385, 0,      1, 0, 40, 0, 0,  1, -1, 1, ST_DIM},
        '{MAGIC,     32'd1, 'h10004, 4,   0,      1, 0, 40, 0, 0,  1, -1, 1, ST_DIM},
        '{MAGIC,     32'd1, 16384, 16384, 1,     15, 0, 40, 0, 0,  4, -1, 1, ST_SIZE},
        '{MAGIC,     32'd1, 4,     4,     2,      1, 0, 40, 0, 0,  1, -1, 1, ST_FORMAT},
        '{MAGIC,     32'd1, 4,     4,     'h100,  1, 0, 40, 0, 0,  1, -1, 1, ST_FORMAT},
        '{MAGIC,     32'd1, 4,     4,     0,      0, 0, 40, 0, 0,  1, -1, 1, ST_MIPS},
        '{MAGIC,     32'd1, 4,     4,     0,      4, 0, 40, 0, 0,  1, -1, 1, ST_MIPS},
        '{MAGIC,     32'd1, 4,     4,     0,      1, 2, 40, 0, 0,  1, -1, 1, ST_LAYOUT},
        '{MAGIC,     32'd1, 6,     4,     0,      1, 1, 40, 0, 0,  1, -1, 1, ST_ALIGN},
        '{MAGIC,     32'd1, 4,     4,     0,      1, 0, 41, 0, 0,  1, -1, 1, ST_SIZE},
        '{MAGIC,     32'd1, 4,     4,     0,      1, 0, 40, 1, 0,  1, -1, 1, ST_SIZE},
        '{MAGIC,     32'd1, 4,     8,     1,      4, 1, 40, 0, 1,  0, -1, 0, ST_OK}
    };

    function automatic int bit_len(logic [31:0] v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    function automatic logic [63:0] chain_total(logic [31:0] w, logic [31:0] h, bit bc7,
                                                logic [31:0] mips);
        logic [63:0] sum, lw, lh;
        sum = 0;
        for (int i = 0; i < 32 && i < mips; i++) begin
            lw = w >> i;
            lh = h >> i;
            if (lw == 0) lw = 1;
            if (lh == 0) lh = 1;
            if (bc7) sum += ((lw + 3) / 4) * ((lh + 3) / 4) * 16;
            else sum += lw * lh * 4;
        end
        return sum;
    endfunction

    function automatic logic [31:0] hdr_word(int pos);
        return {hdr_mem[pos+3], hdr_mem[pos+2], hdr_mem[pos+1], hdr_mem[pos]};
    endfunction

    function automatic void rearm_stream();
        foreach (hdr_mem[i]) hdr_mem[i] = 8'h00;
        seen_bytes   = '0;
        hdr_err      = ST_OK;
        chain_expect = '0;
        hdr_valid    = 1'b0;
    endfunction

    function automatic void evaluate_header();
        logic [31:0] w, h, fmt, mips, off, size, lay;
        hdr_valid = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (hdr_mem[i] != MAGIC[8*i +: 8]) begin
                hdr_err = ST_MAGIC;
                return;
            end
        end
        if (hdr_word(8) != cfg_schema) begin
            hdr_err = ST_VERSION;
            return;
        end
        w = hdr_word(12);
        h = hdr_word(16);
        if (w == 0 || w > cfg_max_dim || h == 0 || h > cfg_max_dim) begin
            hdr_err = ST_DIM;
            return;
        end
        fmt = hdr_word(20);
        if (fmt > 1) begin
            hdr_err = ST_FORMAT;
            return;
        end
        mips = hdr_word(24);
        if (mips == 0 || mips > bit_len(w > h ? w : h) || mips > MAX_MIP_LEVELS_DEF) begin
            hdr_err = ST_MIPS;
            return;
        end
        off  = hdr_word(28);
        size = hdr_word(32);
        lay  = hdr_word(36);
        if (lay > 1) begin
            hdr_err = ST_LAYOUT;
            return;
        end
        if (lay == 1 && (w[1:0] != 0 || h[1:0] != 0)) begin
            hdr_err = ST_ALIGN;
            return;
        end
        chain_expect = chain_total(w, h, lay == 1, mips);
        if (off != HEADER_BYTES || 64'(size) != chain_expect) begin
            hdr_err = ST_SIZE;
            return;
        end
        hdr_err   = ST_OK;
        hdr_valid = 1'b1;
    endfunction

    function automatic t_byte_result predict_byte(logic [7:0] b, logic fin);
        t_byte_result r;
        logic [63:0]  pos;
        bit           fwd;
        pos = seen_bytes;
        fwd = 1'b0;
        if (seen_bytes != '1) seen_bytes++;
        if (pos < HEADER_BYTES) begin
            hdr_mem[int'(pos)] = b;
            if (pos == HEADER_BYTES - 1) evaluate_header();
        end else if (hdr_valid) begin
            fwd = 1'b1;
        end
        r.payload_valid = fwd;
        r.payload_byte  = fwd ? b : 8'h00;
        r.done_res      = fin;
        if (!fin) r.status = hdr_err;
        else if (seen_bytes < HEADER_BYTES) r.status = ST_TRUNC;
        else if (hdr_err != ST_OK) r.status = hdr_err;
        else if (seen_bytes - HEADER_BYTES != chain_expect) r.status = ST_SIZE;
        else r.status = ST_OK;
        if (hdr_valid) begin
            r.tex_width  = 16'(hdr_word(12));
            r.tex_height = 16'(hdr_word(16));
            r.color_srgb = 1'(hdr_word(20));
            r.layout_bc7 = 1'(hdr_word(36));
            r.mip_levels = 5'(hdr_word(24));
        end else begin
            r.tex_width  = '0;
            r.tex_height = '0;
            r.color_srgb = 1'b0;
            r.layout_bc7 = 1'b0;
            r.mip_levels = '0;
        end
        if (fin) rearm_stream();
        return r;
    endfunction

    function automatic void append_word(logic [31:0] v);
        for (int i = 0; i < 4; i++) art_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void pack_header(t_header hd);
        art_q.delete();
        for (int i = 0; i < 8; i++) art_q.push_back(hd.magic[8*i +: 8]);
        append_word(hd.ver);
        append_word(hd.w);
        append_word(hd.h);
        append_word(hd.fmt);
        append_word(hd.mips);
        append_word(hd.off);
        append_word(hd.size);
        append_word(hd.lay);
    endfunction

    function automatic void add_payload(int n);
        for (int i = 0; i < n; i++) art_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [31:0] pick_dim(int top, bit bc7);
        int v;
        if ($urandom_range(0, 3) == 0) v = top;
        else v = $urandom_range(1, top);
        if (bc7) v = (v < 4) ? 4 : (v & ~3);
        return v;
    endfunction

    function automatic logic [31:0] bad_dim();
        case ($urandom_range(0, 2))
            0: return 32'd0;
            1: return 32'(cfg_max_dim) + 32'd1;
            default: return $urandom | 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [31:0] bad_code();
        return $urandom_range(0, 1) ? 32'd2 : ($urandom | 32'd2);
    endfunction

    function automatic void spoil_header(inout t_header hd, input int top);
        int k;
        int v;
        case ($urandom_range(0, 9))
            0: begin
                k = 8 * $urandom_range(0, 7) + $urandom_range(0, 7);
                hd.magic[k] = ~hd.magic[k];
            end
            1: hd.ver  = hd.ver ^ (32'd1 << $urandom_range(0, 31));
            2: hd.w    = bad_dim();
            3: hd.h    = bad_dim();
            4: hd.fmt  = bad_code();
            5: begin
                case ($urandom_range(0, 2))
                    0: hd.mips = 32'd0;
                    1: hd.mips = bit_len(hd.w > hd.h ? hd.w : hd.h) + 1 + $urandom_range(0, 3);
                    default: hd.mips = $urandom | 32'h0000_0100;
                endcase
            end
            6: hd.off  = hd.off ^ (32'd1 << $urandom_range(0, 31));
            7: hd.size = hd.size ^ (32'd1 << $urandom_range(0, 31));
            8: hd.lay  = bad_code();
            default: begin
                hd.lay = 32'd1;
                v = $urandom_range(1, top < 7 ? top : 7);
                if (v % 4 == 0) v--;
                if ($urandom_range(0, 1)) hd.w = v;
                else hd.h = v;
                hd.mips = $urandom_range(1, bit_len(hd.w > hd.h ? hd.w : hd.h));
            end
        endcase
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic push_byte(logic [7:0] b, logic fin, bit pinned, t_status st);
        while (!steady && $urandom_range(0, 99) < 25) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.last    <= fin;
        pin_hold      <= pinned;
        pin_code      <= st;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_artifact(int cut, bit pinned, t_status st);
        int n;
        n = (cut >= 0) ? cut + 1 : art_q.size();
        for (int i = 0; i < n; i++) push_byte(art_q[i], i == n - 1, pinned && i == n - 1, st);
    endtask

    task automatic run_case(t_case c);
        t_header     hd;
        logic [63:0] chain;
        int          n;
        chain = chain_total(c.w, c.h, c.lay == 1, c.mips);
        hd = '{c.magic, c.ver, c.w, c.h, c.fmt, c.mips, c.off, chain[31:0] + c.size_adj, c.lay};
        pack_header(hd);
        n = (c.pay_exact ? int'(chain) : 0) + c.pay_adj;
        add_payload(n);
        send_artifact(c.cut, c.pinned, c.pin_st);
    endtask

    task automatic random_artifact();
        t_header     hd;
        bit          compact, bc7;
        int          top, kind, cut, n, pick;
        logic [31:0] w, h, mips;
        logic [63:0] chain;
        compact = $urandom_range(0, 99) < 60;
        bc7 = cfg_max_dim >= 4 && $urandom_range(0, 2) == 0;
        top = cfg_max_dim;
        if (compact && top > (bc7 ? 8 : 5)) top = bc7 ? 8 : 5;
        w = pick_dim(top, bc7);
        h = pick_dim(top, bc7);
        mips  = $urandom_range(1, bit_len(w > h ? w : h));
        chain = chain_total(w, h, bc7, mips);
        hd = '{MAGIC, cfg_schema, w, h, $urandom_range(0, 1), mips, HEADER_BYTES,
               chain[31:0], bc7};
        cut = -1;
        n = 0;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            if (compact) begin
                pick = $urandom_range(0, 99);
                n = int'(chain);
                if (pick >= 85) n = n - 1;
                else if (pick >= 70) n = n + $urandom_range(1, 3);
            end else begin
                n = $urandom_range(0, 8);
            end
        end else if (kind < 85) begin
            spoil_header(hd, top);
            n = $urandom_range(0, 4);
        end else if (kind < 95) begin
            cut = $urandom_range(0, HEADER_BYTES - 1);
        end
        if (kind < 95) begin
            pack_header(hd);
        end else begin
            art_q.delete();
            n = $urandom_range(1, 60);
        end
        add_payload(n);
        send_artifact(cut, 1'b0, ST_OK);
    endtask

    task automatic random_phase();
        int start;
        start = sent_bytes;
        while (sent_bytes - start < RANDOM_PER_PHASE) random_artifact();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (stream_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] schema, logic [15:0] max_dim);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SCHEMA;
        cfg_data <= schema;
        @(posedge i_clk);
        cfg_schema = schema;
        @(negedge i_clk);
        cfg_idx  <= CFG_MAX_DIM;
        cfg_data <= {16'h0000, max_dim};
        @(posedge i_clk);
        cfg_max_dim = max_dim;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    // transaction monitor and result checker
    always @(posedge i_clk) begin
        t_byte_result want;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            want = predict_byte(in_ch.in_byte, in_ch.last);
            if (pin_hold) want.status = pin_code;
            stream_results_q.push_back(want);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (stream_results_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, res_ch.status);
            end else begin
                want = stream_results_q.pop_front();
                check_field("payload_valid", want.payload_valid, res_ch.payload_valid);
                check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
                check_field("done_res", want.done_res, res_ch.done_res);
                check_field("status", want.status, res_ch.status);
                check_field("tex_width", want.tex_width, res_ch.tex_width);
                check_field("tex_height", want.tex_height, res_ch.tex_height);
                check_field("color_srgb", want.color_srgb, res_ch.color_srgb);
                check_field("layout_bc7", want.layout_bc7, res_ch.layout_bc7);
                check_field("mip_levels", want.mip_levels, res_ch.mip_levels);
            end
        end
    end

    initial begin
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_SCHEMA;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.last    = 1'b0;
        pin_hold      = 1'b0;
        pin_code      = ST_OK;
        steady        = 1'b0;
        fail_count    = 0;
        sent_bytes    = 0;
        cfg_schema    = SCHEMA_RST;
        cfg_max_dim   = MAX_DIM_RST;
        rearm_stream();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_cases[i]) run_case(directed_cases[i]);
        in_ch.valid <= 1'b0;

        write_regs(32'd0, 16'd1);
        random_phase();
        write_regs(32'hFFFF_FFFF, 16'd32768);
        random_phase();
        steady = 1'b1;
        write_regs($urandom, 16'($urandom_range(4, 64)));
        random_phase();
        steady = 1'b0;
        write_regs($urandom, 16'($urandom_range(8, 1024)));
        random_phase();

        wait_idle();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/thv_pkg.sv
rtl/thv_in_if.sv
rtl/thv_out_if.sv
rtl/thv_chain.sv
rtl/texture_header_validator.sv
test/tb_texture_header_validator.sv
